// ===== hdl/dhus_pkg.sv =====
// Shared types, codes and helpers for the dual-host USB switch controller.
package dhus_pkg;

  localparam int unsigned TimerWidthDef = 10;

  localparam int unsigned SettleW  = 10;
  localparam int unsigned VbusW    = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [SettleW-1:0] SettleRst = SettleW'(100);
  localparam logic [VbusW-1:0]   VbusRst   = VbusW'(2500);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SETTLE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_VBUS_THR = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_AUTO_FO  = 2'd2;

  // item kinds
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SWITCH  = 2'd1;
  localparam logic [1:0] OP_RECOVER = 2'd2;
  localparam logic [1:0] OP_START   = 2'd3;

  // switch sequence states
  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_BREAK = 2'd1;
  localparam logic [1:0] M_RECON = 2'd2;
  localparam logic [1:0] M_FAULT = 2'd3;

  // host codes
  localparam logic [1:0] HOST_NONE = 2'd0;
  localparam logic [1:0] HOST_A    = 2'd1;
  localparam logic [1:0] HOST_B    = 2'd2;

  typedef struct packed {
    logic [SettleW-1:0] settle_ms;
    logic [VbusW-1:0]   present_thr_mv;
    logic               auto_failover;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] host;
    logic [VbusW-1:0] vbus_a_mv;
    logic [VbusW-1:0] vbus_b_mv;
    logic       fault_line;
    logic       fault_after_clear;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] current_host;
    logic [1:0] pending_host;
    logic       switch_pending;
    logic       recovery_pending;
    logic [1:0] present_bits;
    logic       path_on;
  } ctl_t;

  typedef struct packed {
    logic       request_accepted;
    logic [1:0] cmd_host;
    logic       cmd_clear_fault;
    logic       cmd_mux_route;
    logic       cmd_power_up;
    logic       cmd_power_down;
    logic       cmd_mux_off;
    logic [1:0] presence;
    logic       data_path_on;
    logic [1:0] active_host;
    logic [1:0] fsm_state;
  } res_t;

  function automatic logic host_seen(input logic [1:0] h, input logic [1:0] pres);
    logic seen;
    seen = 1'b0;
    if (h == HOST_A) seen = pres[0];
    else if (h == HOST_B) seen = pres[1];
    return seen;
  endfunction

endpackage

// ===== hdl/dual_host_usb_switch_fsm_top.sv =====
// Top level of the dual-host USB upstream switch controller.
//
// Break-before-make switch between two upstream hosts, A and B, sharing one
// downstream data path. Each request on the slave stream is a millisecond
// tick, a switch request, a recovery request or a start (kind in s_axis_tuser).
// Every request yields exactly one status word on the master stream carrying
// state, presence, active host and one-shot command pulses. A request is taken
// in every cycle in which the output slot is free or drains: the whole state
// update is one level of logic between the state registers and the output
// register, so it sustains one request per clock unless the sink stalls. The
// output register holds a status word while the sink stalls, and the slave
// side stays ready as long as that word is being taken in the same cycle.
// The settle timer is TIMER_WIDTH bits wide and saturates; with settle_ms at
// or above its maximum value a wait leg never finishes. Configuration writes
// (settle time, VBUS threshold, auto-failover) take effect on the next clock.
module dual_host_usb_switch_fsm_top #(
  parameter int unsigned TIMER_WIDTH = dhus_pkg::TimerWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, from bit 0: host[1:0], vbus_a_mv[17:2], vbus_b_mv[33:18],
  // fault_line[34], fault_after_clear[35], zero pad[39:36]
  input  logic [dhus_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]                    s_axis_tuser,
  // status stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata, from bit 0: fsm_state[1:0], active_host[3:2], data_path_on[4],
  // presence[6:5], cmd_mux_off[7], cmd_power_down[8], cmd_power_up[9],
  // cmd_mux_route[10], cmd_clear_fault[11], cmd_host[13:12],
  // request_accepted[14], zero pad[15]
  output logic [dhus_pkg::OutDataW-1:0] m_axis_tdata,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [dhus_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dhus_pkg::CfgDataW-1:0] cfg_data_i
);
  import dhus_pkg::*;

  cfg_t                   cfg;
  item_t                  item;
  ctl_t                   ctl_q, ctl_d;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
  res_t                   res_d, res_q;
  logic                   out_valid_q;
  logic                   accept;

  dhus_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // unpack the request
  always_comb begin
    item.op                = s_axis_tuser;
    item.host              = s_axis_tdata[1:0];
    item.vbus_a_mv         = s_axis_tdata[17:2];
    item.vbus_b_mv         = s_axis_tdata[33:18];
    item.fault_line        = s_axis_tdata[34];
    item.fault_after_clear = s_axis_tdata[35];
  end

  dhus_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .item_i    (item),
    .cfg_i     (cfg),
    .ctl_i     (ctl_q),
    .elapsed_i (elapsed_q),
    .ctl_o     (ctl_d),
    .elapsed_o (elapsed_d),
    .res_o     (res_d)
  );

  // ready whenever the output slot is free or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.mode             <= M_IDLE;
      ctl_q.current_host     <= HOST_NONE;
      ctl_q.pending_host     <= HOST_NONE;
      ctl_q.switch_pending   <= 1'b0;
      ctl_q.recovery_pending <= 1'b0;
      ctl_q.present_bits     <= '0;
      ctl_q.path_on          <= 1'b0;
      elapsed_q              <= '0;
      out_valid_q            <= 1'b0;
    end else begin
      if (accept) begin
        ctl_q     <= ctl_d;
        elapsed_q <= elapsed_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

endmodule

// ===== hdl/dhus_cfg.sv =====
// Configuration register file for the switch controller.
module dhus_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dhus_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dhus_pkg::CfgDataW-1:0] cfg_data_i,
  output dhus_pkg::cfg_t                cfg_o
);
  import dhus_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SETTLE:   cfg_d.settle_ms      = cfg_data_i[SettleW-1:0];
        REG_VBUS_THR: cfg_d.present_thr_mv = cfg_data_i[VbusW-1:0];
        REG_AUTO_FO:  cfg_d.auto_failover  = cfg_data_i[0];
        default:      cfg_d = cfg_q; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms      <= SettleRst;
      cfg_q.present_thr_mv <= VbusRst;
      cfg_q.auto_failover  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/dhus_step.sv =====
// Next-state and status logic for one request of the switch controller.
module dhus_step #(
  parameter int unsigned TIMER_WIDTH = dhus_pkg::TimerWidthDef
) (
  input  dhus_pkg::item_t        item_i,
  input  dhus_pkg::cfg_t         cfg_i,
  input  dhus_pkg::ctl_t         ctl_i,
  input  logic [TIMER_WIDTH-1:0] elapsed_i,
  output dhus_pkg::ctl_t         ctl_o,
  output logic [TIMER_WIDTH-1:0] elapsed_o,
  output dhus_pkg::res_t         res_o
);
  import dhus_pkg::*;

  localparam int unsigned CmpW = (TIMER_WIDTH > SettleW) ? TIMER_WIDTH : SettleW;
  localparam logic [TIMER_WIDTH-1:0] TimerCap = {TIMER_WIDTH{1'b1}};

  logic [1:0]             pres_new;
  logic [1:0]             backup;
  logic [TIMER_WIDTH-1:0] el_inc;
  logic                   leg_done;
  ctl_t                   c;
  res_t                   r;

  always_comb begin
    pres_new = {item_i.vbus_b_mv > cfg_i.present_thr_mv,
                item_i.vbus_a_mv > cfg_i.present_thr_mv};
    el_inc   = (elapsed_i == TimerCap) ? elapsed_i : elapsed_i + 1'b1;
    leg_done = CmpW'(el_inc) > CmpW'(cfg_i.settle_ms);
    backup   = (ctl_i.current_host == HOST_A) ? HOST_B : HOST_A;

    c         = ctl_i;
    elapsed_o = elapsed_i;
    r         = '0;

    unique case (item_i.op)
      OP_TICK: begin
        c.present_bits = pres_new;
        if (item_i.fault_line && c.mode != M_FAULT) begin
          c.mode             = M_FAULT;
          c.recovery_pending = 1'b0;
        end
        r.fsm_state = c.mode;
        unique case (c.mode)
          M_IDLE: begin
            if (c.switch_pending) begin
              r.cmd_mux_off = 1'b1;
              c.path_on     = 1'b0;
              elapsed_o     = '0;
              c.mode        = M_BREAK;
            end else if (cfg_i.auto_failover && !host_seen(c.current_host, pres_new)
                         && host_seen(backup, pres_new)) begin
              c.pending_host   = backup;
              c.switch_pending = 1'b1;
            end
          end
          M_BREAK: begin
            elapsed_o = el_inc;
            if (leg_done) begin
              r.cmd_power_down = 1'b1;
              r.cmd_power_up   = 1'b1;
              r.cmd_host       = c.pending_host;
              c.current_host   = c.pending_host;
              elapsed_o        = '0;
              c.mode           = M_RECON;
            end
          end
          M_RECON: begin
            elapsed_o = el_inc;
            if (leg_done) begin
              r.cmd_mux_route  = 1'b1;
              r.cmd_host       = c.current_host;
              c.path_on        = 1'b1;
              c.switch_pending = 1'b0;
              c.mode           = M_IDLE;
            end
          end
          default: begin // fault
            if (c.recovery_pending) begin
              r.cmd_clear_fault  = 1'b1;
              c.recovery_pending = 1'b0;
              if (!item_i.fault_after_clear) begin
                // restart on the current host
                c.switch_pending = 1'b0;
                r.cmd_power_up   = 1'b1;
                r.cmd_mux_route  = 1'b1;
                r.cmd_host       = c.current_host;
                c.pending_host   = c.current_host;
                c.path_on        = 1'b1;
                c.mode           = M_IDLE;
              end
            end
          end
        endcase
      end
      OP_SWITCH: begin
        if (host_seen(item_i.host, c.present_bits) && item_i.host != c.current_host) begin
          c.pending_host     = item_i.host;
          c.switch_pending   = 1'b1;
          r.request_accepted = 1'b1;
        end
        r.fsm_state = c.mode;
      end
      OP_RECOVER: begin
        if (c.mode == M_FAULT) begin
          c.recovery_pending = 1'b1;
          r.request_accepted = 1'b1;
        end
        r.fsm_state = c.mode;
      end
      default: begin // start
        r.cmd_power_up  = 1'b1;
        r.cmd_mux_route = 1'b1;
        r.cmd_host      = item_i.host;
        c.current_host  = item_i.host;
        c.pending_host  = item_i.host;
        c.path_on       = 1'b1;
        c.mode          = M_IDLE;
        r.fsm_state     = c.mode;
      end
    endcase

    r.active_host  = c.current_host;
    r.data_path_on = c.path_on;
    r.presence     = c.present_bits;
  end

  assign ctl_o = c;
  assign res_o = r;

endmodule
